/* hw/rtl/rwo_pkg.sv */
// shared types, constants and the quarter-wave sine table of the oscillator
`default_nettype none

package rwo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 24;

    localparam int SINE_DEPTH = (1 << SINE_TABLE_BITS) + 1;
    localparam int SINE_AW    = SINE_TABLE_BITS + 1;
    localparam int SINE_W     = 21;

    localparam int PHASE_W   = 32;
    localparam int GAIN_W    = 16;
    localparam int STEP_W    = 32;
    localparam int PROG_W    = 25;
    localparam int PROG_FRAC = 24;
    localparam int WAVE_W    = 22;
    localparam int TERM_W    = 24;
    localparam int TERM_SHIFT = 15;
    localparam int SUM_W     = ((SAMPLE_BITS > TERM_W) ? SAMPLE_BITS : TERM_W) + 1;

    localparam int MUL_A_W = STEP_W + 1;
    localparam int MUL_B_W = PROG_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [PROG_W-1:0] ONE_Q24 = PROG_W'(1 << PROG_FRAC);
    localparam logic signed [WAVE_W-1:0] ONE_Q20 = WAVE_W'(1 << 20);
    localparam logic signed [WAVE_W-1:0] THREE_Q20 = WAVE_W'(3 << 20);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_END   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE  = 3'd5;

    localparam int ITEM_Q_DEPTH = 2;
    localparam int ITEM_Q_AW    = 1;
    localparam int ITEM_Q_CW    = 2;
    localparam int RES_Q_DEPTH  = 4;
    localparam int RES_Q_AW     = 2;
    localparam int RES_Q_CW     = 3;

    typedef enum logic [1:0] {
        WAVE_SINE,
        WAVE_SQUARE,
        WAVE_SAW,
        WAVE_TRI
    } t_wave;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_GAIN,
        BS_STEP,
        BS_WAVE,
        BS_OUT
    } t_bstate;

    typedef struct packed {
        t_wave              shape;
        logic [GAIN_W-1:0]  gain_start;
        logic [GAIN_W-1:0]  gain_end;
        logic [STEP_W-1:0]  step_start;
        logic [STEP_W-1:0]  step_end;
        logic [PROG_W-1:0]  ramp_rate;
    } t_cfg;

    typedef struct packed {
        logic                          note_start;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } t_result;

    typedef logic [SINE_W-1:0] t_sine_rom [SINE_DEPTH];

    // taylor series through x^15 on a q30 angle, rounded to q20
    function automatic t_sine_rom sine_rom_init();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            x    = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 64'sd512) >>> 10;
            if (sum > 64'sd1048576) begin
                sum = 64'sd1048576;
            end
            rom[k] = SINE_W'(sum);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_rom_init();

endpackage

`default_nettype wire

/* hw/rtl/rwo_front.sv */
// front end: takes input items and holds them in a short queue for the back end
`default_nettype none

module rwo_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic                                  i_note_start,
    input  wire logic signed [rwo_pkg::SAMPLE_BITS-1:0] i_in_sample,
    output rwo_pkg::t_item                             o_item,
    output logic                                       o_item_vld,
    input  wire logic                                  i_item_take
);
    import rwo_pkg::*;

    t_item                r_mem [ITEM_Q_DEPTH];
    logic [ITEM_Q_AW-1:0] r_wr_ptr;
    logic [ITEM_Q_AW-1:0] r_rd_ptr;
    logic [ITEM_Q_CW-1:0] r_count;
    logic [ITEM_Q_CW-1:0] n_count;
    logic                 wr_en;
    logic                 rd_en;
    t_item                item_in;

    assign full       = (r_count == ITEM_Q_CW'(ITEM_Q_DEPTH));
    assign o_item_vld = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign wr_en      = push && !full;
    assign rd_en      = i_item_take && o_item_vld;

    always_comb begin
        item_in.note_start = i_note_start;
        item_in.sample     = i_in_sample;
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rwo_res_q.sv */
// result queue between the back end and the output ports
`default_nettype none

module rwo_res_q (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire rwo_pkg::t_result                      i_res,
    input  wire logic                                  i_res_push,
    output logic [rwo_pkg::RES_Q_CW-1:0]               o_count,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [rwo_pkg::SAMPLE_BITS-1:0]     o_out_sample,
    output logic                                       o_clipped
);
    import rwo_pkg::*;

    t_result             r_mem [RES_Q_DEPTH];
    logic [RES_Q_AW-1:0] r_wr_ptr;
    logic [RES_Q_AW-1:0] r_rd_ptr;
    logic [RES_Q_CW-1:0] r_count;
    logic [RES_Q_CW-1:0] n_count;
    logic                rd_en;
    t_result             head;

    assign empty        = (r_count == '0);
    assign o_count      = r_count;
    assign rd_en        = pop && !empty;
    assign head         = r_mem[r_rd_ptr];
    assign o_out_sample = head.sample;
    assign o_clipped    = head.clipped;

    always_comb begin
        n_count = r_count;
        if (i_res_push && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !i_res_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_res_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rwo_back.sv */
// back end: sequencer around one shared multiplier, phase and ramp state, sine rom
`default_nettype none

module rwo_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rwo_pkg::t_cfg                 i_cfg,
    input  wire rwo_pkg::t_item                i_item,
    input  wire logic                          i_item_vld,
    output logic                               o_item_take,
    input  wire logic [rwo_pkg::RES_Q_CW-1:0]  i_res_count,
    output rwo_pkg::t_result                   o_res,
    output logic                               o_res_push
);
    import rwo_pkg::*;

    t_bstate                       r_state;
    t_bstate                       n_state;
    logic [PHASE_W-1:0]            r_phase;
    logic [PHASE_W-1:0]            n_phase;
    logic [PROG_W-1:0]             r_prog;
    logic [PROG_W-1:0]             n_prog;
    logic [SINE_W-1:0]             r_sine;
    logic signed [WAVE_W-1:0]      r_wave;
    logic [GAIN_W-1:0]             r_gain;
    logic [STEP_W-1:0]             r_step;
    logic signed [MUL_P_W-1:0]     r_prod;
    logic signed [SAMPLE_BITS-1:0] r_x;

    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic [PHASE_W-1:0]            upd_phase;
    logic [PROG_W:0]               prog_sum;
    logic [PROG_W-1:0]             upd_prog;
    logic [PHASE_W-1:0]            base_phase;
    logic [PROG_W-1:0]             base_prog;
    logic [PHASE_W-1:0]            eff_phase;
    logic [PROG_W-1:0]             eff_prog;
    logic                          load_ok;
    logic [SINE_TABLE_BITS-1:0]    rom_idx;
    logic [SINE_AW-1:0]            rom_addr;
    logic signed [WAVE_W-1:0]      wave;
    logic signed [TERM_W-1:0]      term;
    logic signed [SUM_W-1:0]       sum;
    logic [SUM_W-SAMPLE_BITS:0]    sum_top;
    logic                          ovf;

    always_comb begin
        upd_phase  = r_phase + r_step;
        prog_sum   = {1'b0, r_prog} + {1'b0, i_cfg.ramp_rate};
        upd_prog   = (prog_sum > {1'b0, ONE_Q24}) ? ONE_Q24 : prog_sum[PROG_W-1:0];
        base_phase = (r_state == BS_OUT) ? upd_phase : r_phase;
        base_prog  = (r_state == BS_OUT) ? upd_prog : r_prog;
        eff_phase  = i_item.note_start ? '0 : base_phase;
        eff_prog   = i_item.note_start ? '0 : base_prog;

        rom_idx  = eff_phase[PHASE_W-3 -: SINE_TABLE_BITS];
        rom_addr = eff_phase[PHASE_W-2]
                 ? SINE_AW'(SINE_DEPTH - 1) - {1'b0, rom_idx}
                 : {1'b0, rom_idx};

        unique case (i_cfg.shape)
            WAVE_SINE: begin
                wave = r_phase[PHASE_W-1] ? -WAVE_W'({1'b0, r_sine})
                                          : WAVE_W'({1'b0, r_sine});
            end
            WAVE_SQUARE: begin
                wave = r_phase[PHASE_W-1] ? -ONE_Q20 : ONE_Q20;
            end
            WAVE_SAW: begin
                wave = ONE_Q20 - WAVE_W'({1'b0, r_phase[PHASE_W-1:11]});
            end
            WAVE_TRI: begin
                wave = r_phase[PHASE_W-1] ? WAVE_W'(r_phase[PHASE_W-1:10]) - THREE_Q20
                                          : ONE_Q20 - WAVE_W'(r_phase[PHASE_W-1:10]);
            end
            default: begin
                wave = '0;
            end
        endcase

        // floor of wave times gain over 2^15, then add and saturate
        term    = r_prod[TERM_SHIFT +: TERM_W];
        sum     = SUM_W'(r_x) + SUM_W'(term);
        sum_top = sum[SUM_W-1:SAMPLE_BITS-1];
        ovf     = !((&sum_top) || !(|sum_top));
        o_res.clipped = ovf;
        if (ovf) begin
            o_res.sample = sum[SUM_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            o_res.sample = sum[SAMPLE_BITS-1:0];
        end

        load_ok = i_item_vld
               && (((r_state == BS_IDLE) && (i_res_count < RES_Q_CW'(RES_Q_DEPTH)))
               ||  ((r_state == BS_OUT) && (i_res_count < RES_Q_CW'(RES_Q_DEPTH - 1))));

        n_state     = r_state;
        n_phase     = r_phase;
        n_prog      = r_prog;
        o_item_take = 1'b0;
        o_res_push  = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        unique case (r_state)
            BS_IDLE: begin
                if (load_ok) begin
                    o_item_take = 1'b1;
                    n_phase     = eff_phase;
                    n_prog      = eff_prog;
                    n_state     = BS_GAIN;
                end
            end
            BS_GAIN: begin
                mul_a   = MUL_A_W'($signed({1'b0, i_cfg.gain_end}))
                        - MUL_A_W'($signed({1'b0, i_cfg.gain_start}));
                mul_b   = $signed({1'b0, r_prog});
                n_state = BS_STEP;
            end
            BS_STEP: begin
                mul_a   = $signed({1'b0, i_cfg.step_end}) - $signed({1'b0, i_cfg.step_start});
                mul_b   = $signed({1'b0, r_prog});
                n_state = BS_WAVE;
            end
            BS_WAVE: begin
                mul_a   = MUL_A_W'(r_wave);
                mul_b   = MUL_B_W'($signed({1'b0, r_gain}));
                n_state = BS_OUT;
            end
            BS_OUT: begin
                o_res_push = 1'b1;
                n_phase    = upd_phase;
                n_prog     = upd_prog;
                n_state    = BS_IDLE;
                if (load_ok) begin
                    o_item_take = 1'b1;
                    n_phase     = eff_phase;
                    n_prog      = eff_prog;
                    n_state     = BS_GAIN;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_phase <= '0;
            r_prog  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_prog  <= n_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine <= SINE_ROM[rom_addr];
        r_prod <= MUL_P_W'(mul_a * mul_b);
        if (o_item_take) begin
            r_x <= i_item.sample;
        end
        if (r_state == BS_GAIN) begin
            r_wave <= wave;
        end
        if (r_state == BS_STEP) begin
            r_gain <= i_cfg.gain_start + r_prod[PROG_FRAC +: GAIN_W];
        end
        if (r_state == BS_WAVE) begin
            r_step <= i_cfg.step_start + r_prod[PROG_FRAC +: STEP_W];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ramped_waveform_oscillator_top.sv */
// top level: configuration registers, front end, back end and result queue
`default_nettype none

// Ramped waveform oscillator. Each input item carries one buffer sample and a
// note start flag; the block adds one sample of a sine, square, saw or triangle
// tone to it and returns the saturated sum with a clipped flag. Gain and phase
// step glide linearly from their start to end values as the ramp progresses.
// The back end runs the gain glide, the step glide and the waveform-times-gain
// product through a single shared multiplier, one per cycle, and finishes the
// sum in the state after them, where it may already take the next item if the
// result queue has room. An item goes through the front queue, the back-end
// states GAIN, STEP, WAVE and OUT and then the result queue. Two input items
// and four results can wait. Configuration writes are registered without
// waiting for idle, and are meant for times when no item is in flight.

module ramped_waveform_oscillator_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic                                   i_note_start,
    input  wire logic signed [rwo_pkg::SAMPLE_BITS-1:0] i_in_sample,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [rwo_pkg::SAMPLE_BITS-1:0]      o_out_sample,
    output logic                                        o_clipped,
    input  wire logic                                   i_cfg_we,
    input  wire logic [rwo_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [rwo_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import rwo_pkg::*;

    t_cfg                r_cfg;
    t_cfg                n_cfg;
    t_item               item;
    logic                item_vld;
    logic                item_take;
    t_result             res;
    logic                res_push;
    logic [RES_Q_CW-1:0] res_count;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAVE_SHAPE: n_cfg.shape      = t_wave'(i_cfg_data[1:0]);
                CFG_GAIN_START: n_cfg.gain_start = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_END:   n_cfg.gain_end   = i_cfg_data[GAIN_W-1:0];
                CFG_STEP_START: n_cfg.step_start = i_cfg_data[STEP_W-1:0];
                CFG_STEP_END:   n_cfg.step_end   = i_cfg_data[STEP_W-1:0];
                CFG_RAMP_RATE:  n_cfg.ramp_rate  = i_cfg_data[PROG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    rwo_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_note_start (i_note_start),
        .i_in_sample  (i_in_sample),
        .o_item       (item),
        .o_item_vld   (item_vld),
        .i_item_take  (item_take)
    );

    rwo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (item),
        .i_item_vld  (item_vld),
        .o_item_take (item_take),
        .i_res_count (res_count),
        .o_res       (res),
        .o_res_push  (res_push)
    );

    rwo_res_q u_res_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res        (res),
        .i_res_push   (res_push),
        .o_count      (res_count),
        .empty        (empty),
        .pop          (pop),
        .o_out_sample (o_out_sample),
        .o_clipped    (o_clipped)
    );

endmodule

`default_nettype wire
